[sv/lkvc_pkg.sv]
// Package for the LRU key-value cache: operation codes, field widths and
// reset constants. No dependencies.
package lkvc_pkg;

    localparam int KIND_W = 2;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = 32;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Operation codes; the fourth code is a no-op
    localparam kind_t KIND_GET   = 2'd0;
    localparam kind_t KIND_PUT   = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

[sv/lkvc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while the read enable is low. No dependencies.
module lkvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/lru_key_value_cache_top.sv]
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and lkvc_ram (value store).

// One operation (get, put or clear) is taken every clock cycle while a held
// result does not stall the flow: the word is captured in an input register,
// the key is compared against every stored key in parallel and the recency
// ranks, valid bits, counters and value RAM are updated together, and the
// result lands in the output register. The compare and rank update span all
// ENTRIES slots in the lookup stage. There is no clearing pass after reset;
// the cache is ready at once. Capacity must be written by the user only while
// the cache is idle; the block itself does not enforce this. 0 acts as 1 and
// values above ENTRIES act as ENTRIES. Occupancy and counters show the state
// after the operation whose result is on the output.
module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lkvc_pkg::kind_t       kind,
    input  lkvc_pkg::key_t        key,
    input  lkvc_pkg::val_t        write_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output lkvc_pkg::val_t        read_value,
    output logic                  evicted,
    output logic [lkvc_pkg::OCC_W-1:0] occupancy,
    output lkvc_pkg::cnt_t        hit_count,
    output lkvc_pkg::cnt_t        miss_count,
    output lkvc_pkg::cnt_t        eviction_count
);

    import lkvc_pkg::*;

    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int COUNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W   = ((COUNT_W > CAP_W) ? COUNT_W : CAP_W) + 1;

    // Configuration
    logic [CAP_W-1:0] capacity_reg;

    // Input stage
    logic  s1_valid_reg;
    kind_t s1_kind_reg;
    key_t  s1_key_reg;
    val_t  s1_wval_reg;

    // Output stage
    logic out_valid_reg;
    logic out_hit_reg;
    logic out_evicted_reg;
    logic out_rsel_reg;

    // Cache state
    key_t              key_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    cnt_t hits_reg, hits_next;
    cnt_t misses_reg, misses_next;
    cnt_t evicts_reg, evicts_next;

    // Lookup results
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] lru_hot;
    logic               hit_any;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  lru_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  ins_slot;
    logic [RANK_W-1:0]  hit_rank;
    logic [COUNT_W-1:0] count_m1;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict_need;

    // Handshake and control
    logic out_free;
    logic s1_fire;
    logic op_hit;
    logic op_evict;
    logic key_we;
    logic ram_we;
    logic ram_re;
    logic [SLOT_W-1:0] ram_wr_addr;
    val_t ram_rd_data;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg <= kind;
            s1_key_reg  <= key;
            s1_wval_reg <= write_value;
        end
    end

    // Parallel key compare, LRU pick and lowest free slot
    always_comb
    begin
        count_m1  = count_reg - COUNT_W'(1);
        hit_slot  = '0;
        lru_slot  = '0;
        free_slot = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == s1_key_reg);
            lru_hot[i] = valid_reg[i] && (rank_reg[i] == count_m1[RANK_W-1:0]);
            if (match[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
            if (lru_hot[i])
            begin
                lru_slot = lru_slot | SLOT_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
        hit_any  = |match;
        hit_rank = rank_reg[hit_slot];
    end

    // Effective capacity and eviction test
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
        evict_need = ((CMP_W'(count_reg) + CMP_W'(1)) > cap_eff) && (count_reg != '0);
        ins_slot   = evict_need ? lru_slot : free_slot;
    end

    // Next state for one operation
    always_comb
    begin
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        op_hit      = 1'b0;
        op_evict    = 1'b0;
        key_we      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wr_addr = ins_slot;
        if (s1_fire)
        begin
            case (s1_kind_reg)
                KIND_GET:
                begin
                    if (hit_any)
                    begin
                        op_hit    = 1'b1;
                        ram_re    = 1'b1;
                        hits_next = hits_reg + CNT_W'(1);
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (match[i])
                            begin
                                rank_next[i] = '0;
                            end
                            else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                            begin
                                rank_next[i] = rank_reg[i] + RANK_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        misses_next = misses_reg + CNT_W'(1);
                    end
                end
                KIND_PUT:
                begin
                    ram_we = 1'b1;
                    if (hit_any)
                    begin
                        op_hit      = 1'b1;
                        ram_wr_addr = hit_slot;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (match[i])
                            begin
                                rank_next[i] = '0;
                            end
                            else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                            begin
                                rank_next[i] = rank_reg[i] + RANK_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        key_we = 1'b1;
                        // Evicted entry is the one replaced; all others age
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (SLOT_W'(i) == ins_slot)
                            begin
                                rank_next[i] = '0;
                            end
                            else if (valid_reg[i])
                            begin
                                rank_next[i] = rank_reg[i] + RANK_W'(1);
                            end
                        end
                        valid_next[ins_slot] = 1'b1;
                        if (evict_need)
                        begin
                            op_evict    = 1'b1;
                            evicts_next = evicts_reg + CNT_W'(1);
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    valid_next = '0;
                    count_next = '0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        rank_next[i] = '0;
                    end
                end
                default:
                begin
                    // unused code: no change
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            count_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
            rank_reg   <= rank_next;
        end
    end

    // Key store, compared in parallel
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg[ins_slot] <= s1_key_reg;
        end
    end

    // Value store
    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (s1_wval_reg),
        .rd_en   (ram_re),
        .rd_addr (hit_slot),
        .rd_data (ram_rd_data)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_hit_reg     <= op_hit;
            out_evicted_reg <= op_evict;
            out_rsel_reg    <= ram_re;
        end
    end

    // State only moves when a result word is loaded, so it matches the word held
    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign evicted        = out_evicted_reg;
    assign read_value     = out_rsel_reg ? ram_rd_data : '0;
    assign occupancy      = OCC_W'(CMP_W'(count_reg));
    assign hit_count      = hits_reg;
    assign miss_count     = misses_reg;
    assign eviction_count = evicts_reg;

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("valid count disagrees with valid bits");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one slot");

    a_lru_found: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> $onehot(lru_hot))
        else $error("recency ranks not a permutation");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=>
            (s1_valid_reg && $stable(s1_key_reg) && $stable(count_reg)))
        else $error("lookup stage moved while result stalled");

    a_evict_counted: assert property (@(posedge clk) disable iff (!rst_n)
        op_evict |=> (evicts_reg == $past(evicts_reg) + CNT_W'(1)) && out_evicted_reg)
        else $error("eviction not counted");
`endif

endmodule
